>>> rtl/core/shabs_pkg.sv
// ----------------------------------------------------------------------------
// shabs_pkg
// Types, constants and round functions shared by the byte-stream SHA-256
// controller, datapath and top level.
// ----------------------------------------------------------------------------
package shabs_pkg;

  localparam int COUNT_W = 61;

  // Opcodes of the message channel
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  localparam logic [31:0] INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        length_overflow;
  } dig_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUNDS,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BYTE_MSG,
    BYTE_MARK,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       shift;
    byte_sel_t  byte_sel;
    logic [2:0] len_idx;
    logic       count_inc;
    logic       set_ovf;
    logic       init_v;
    logic       round;
    logic [5:0] round_idx;
    logic       fold;
    logic       load_out;
    logic [2:0] out_idx;
    logic       reinit;
  } cmd_t;

  typedef struct packed {
    logic count_full;
    logic out_free;
  } status_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> rtl/core/shabs_ctrl.sv
// ----------------------------------------------------------------------------
// shabs_ctrl
// Sequencer: byte intake, padding, round count and digest word emission.
// ----------------------------------------------------------------------------
module shabs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  input  logic                msg_op,
  output logic                msg_stall,
  input  shabs_pkg::status_t  status,
  output shabs_pkg::cmd_t     cmd
);

  shabs_pkg::state_t state, state_next;
  logic [5:0] fill;
  logic [5:0] rnd;
  logic [2:0] widx;
  logic       mark_done;
  logic       in_len;
  logic       accept;

  assign msg_stall = rst | (state != shabs_pkg::ST_IDLE);
  assign accept    = msg_valid & ~msg_stall;

  always_comb begin
    state_next = state;
    case (state)
      shabs_pkg::ST_IDLE: begin
        if (accept && msg_op == shabs_pkg::OP_FINISH) begin
          state_next = shabs_pkg::ST_PAD;
        end else if (accept && !status.count_full && fill == shabs_pkg::FILL_LAST) begin
          state_next = shabs_pkg::ST_ROUNDS;
        end
      end
      shabs_pkg::ST_PAD: begin
        if (fill == shabs_pkg::FILL_LAST) state_next = shabs_pkg::ST_ROUNDS;
      end
      shabs_pkg::ST_ROUNDS: begin
        if (rnd == shabs_pkg::ROUND_LAST) state_next = shabs_pkg::ST_FOLD;
      end
      shabs_pkg::ST_FOLD: begin
        if (in_len) state_next = shabs_pkg::ST_EMIT;
        else if (mark_done) state_next = shabs_pkg::ST_PAD;
        else state_next = shabs_pkg::ST_IDLE;
      end
      shabs_pkg::ST_EMIT: begin
        if (status.out_free && widx == shabs_pkg::WORD_LAST) state_next = shabs_pkg::ST_IDLE;
      end
      default: state_next = shabs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = shabs_pkg::BYTE_MSG;
    cmd.len_idx   = fill[2:0];
    cmd.round_idx = rnd;
    cmd.out_idx   = widx;
    case (state)
      shabs_pkg::ST_IDLE: begin
        if (accept && msg_op == shabs_pkg::OP_ABSORB) begin
          if (status.count_full) begin
            cmd.set_ovf = 1'b1;
          end else begin
            cmd.shift     = 1'b1;
            cmd.count_inc = 1'b1;
          end
        end
      end
      shabs_pkg::ST_PAD: begin
        cmd.shift = 1'b1;
        if (!mark_done) cmd.byte_sel = shabs_pkg::BYTE_MARK;
        else if (in_len || fill == shabs_pkg::LEN_START) cmd.byte_sel = shabs_pkg::BYTE_LEN;
        else cmd.byte_sel = shabs_pkg::BYTE_ZERO;
      end
      shabs_pkg::ST_ROUNDS: cmd.round = 1'b1;
      shabs_pkg::ST_FOLD:   cmd.fold = 1'b1;
      shabs_pkg::ST_EMIT: begin
        cmd.load_out = status.out_free;
        cmd.reinit   = status.out_free && widx == shabs_pkg::WORD_LAST;
      end
      default: cmd = '0;
    endcase
    cmd.init_v = cmd.shift && fill == shabs_pkg::FILL_LAST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shabs_pkg::ST_IDLE;
      fill      <= '0;
      rnd       <= '0;
      widx      <= '0;
      mark_done <= 1'b0;
      in_len    <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.shift) fill <= fill + 6'd1;
      if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.load_out) widx <= widx + 3'd1;
      if (cmd.reinit) begin
        mark_done <= 1'b0;
        in_len    <= 1'b0;
      end else if (cmd.shift) begin
        if (cmd.byte_sel == shabs_pkg::BYTE_MARK) mark_done <= 1'b1;
        if (cmd.byte_sel == shabs_pkg::BYTE_LEN) in_len <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/shabs_dp.sv
// ----------------------------------------------------------------------------
// shabs_dp
// Datapath: 16-word schedule window, working variables, chaining state,
// length counter and the digest output register.
// ----------------------------------------------------------------------------
module shabs_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  shabs_pkg::cmd_t     cmd,
  output shabs_pkg::status_t  status,
  output logic                dig_valid,
  input  logic                dig_stall,
  output shabs_pkg::dig_t     dig
);

  logic [511:0]                   win;
  logic [31:0]                    v [0:7];
  logic [31:0]                    hs [0:7];
  logic [shabs_pkg::COUNT_W-1:0]  byte_count;
  logic                           ovf;

  logic [7:0][7:0] len_bytes;
  logic [7:0]      in_byte;
  logic [31:0]     w0, w1, w9, w14, w_new;
  logic [31:0]     t1, t2;

  assign len_bytes = {byte_count, 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      shabs_pkg::BYTE_MSG:  in_byte = data_byte;
      shabs_pkg::BYTE_MARK: in_byte = shabs_pkg::PAD_MARK;
      shabs_pkg::BYTE_LEN:  in_byte = len_bytes[~cmd.len_idx];
      default:              in_byte = 8'h00;
    endcase
  end

  // Oldest word sits at the top of the window
  assign w0    = win[511:480];
  assign w1    = win[479:448];
  assign w9    = win[223:192];
  assign w14   = win[63:32];
  assign w_new = w0 + shabs_pkg::ssig0(w1) + w9 + shabs_pkg::ssig1(w14);

  assign t1 = v[7] + shabs_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shabs_pkg::ROUND_K[cmd.round_idx] + w0;
  assign t2 = shabs_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign status.count_full = &byte_count;
  assign status.out_free   = ~dig_valid | ~dig_stall;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win <= {win[503:0], in_byte};
    end else if (cmd.round) begin
      win <= {win[479:0], w_new};
    end
    if (cmd.init_v) begin
      v <= hs;
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (cmd.load_out) begin
      dig.digest_word     <= hs[cmd.out_idx];
      dig.word_index      <= cmd.out_idx;
      dig.last            <= (cmd.out_idx == shabs_pkg::WORD_LAST);
      dig.length_overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs         <= shabs_pkg::INIT_H;
      byte_count <= '0;
      ovf        <= 1'b0;
      dig_valid  <= 1'b0;
    end else begin
      if (cmd.reinit) begin
        hs         <= shabs_pkg::INIT_H;
        byte_count <= '0;
        ovf        <= 1'b0;
      end else begin
        if (cmd.fold) begin
          for (int i = 0; i < 8; i++) hs[i] <= hs[i] + v[i];
        end
        if (cmd.count_inc) byte_count <= byte_count + 1'b1;
        if (cmd.set_ovf) ovf <= 1'b1;
      end
      if (cmd.load_out) dig_valid <= 1'b1;
      else if (!dig_stall) dig_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: absorb bytes one per transfer, finish to pad,
// compress and return the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
//
//  channel | signals                  | payload        | direction
//  --------+--------------------------+----------------+----------
//  msg     | msg_valid / msg_stall    | op, data_byte  | in
//  dig     | dig_valid / dig_stall    | digest_word,   | out
//          |                          | word_index,    |
//          |                          | last,          |
//          |                          | length_overflow|
//
// An absorb transfer takes in one byte; the 64th byte of a block then holds
// msg_stall for 64 rounds (one round per cycle) and the fold of the working
// variables into the chaining state. A finish inserts one pad byte per cycle
// up to the block end (one or two blocks of rounds), then loads the eight
// digest words one per cycle as dig_stall allows; the next message may start
// once the last word sits in the output register. Reset is synchronous and
// clears the sequencer, length counter, overflow flag and output valid; the
// chaining state returns to the standard initial values. A stalled digest
// word holds.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_stall,
  input  shabs_pkg::msg_t  msg,
  output logic             dig_valid,
  input  logic             dig_stall,
  output shabs_pkg::dig_t  dig
);

  shabs_pkg::cmd_t    cmd;
  shabs_pkg::status_t status;

  // Sequencer decides what the datapath does each cycle
  shabs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_op    (msg.op),
    .msg_stall (msg_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Schedule window, rounds, chaining state and output register
  shabs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (msg.data_byte),
    .cmd       (cmd),
    .status    (status),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  // Digest words go out back to back: the next word loads on the transfer
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && !dig.last |=> dig_valid)
    else $error("gap between digest words");

  // Word index advances by one from transfer to transfer within a digest
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && !dig.last |=>
      dig.word_index == $past(dig.word_index) + 3'd1)
    else $error("digest word index out of order");

  // After the last word no further word is pending: a new digest needs rounds
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && dig.last |=> !dig_valid)
    else $error("digest word after last");

endmodule
